### hdl/cpdq_pkg.sv
package cpdq_pkg;

  localparam int PHASE_BITS = 32;
  localparam int FRAC_BITS  = 30;
  localparam int COEF_BITS  = 31;
  localparam int ATAN_COUNT = 24;

  typedef logic signed [PHASE_BITS-1:0] trig_t;
  typedef logic [1:0]                   quad_t;

  localparam logic signed [COEF_BITS-1:0] INV_SQRT6  = 31'sd438353264;
  localparam logic signed [COEF_BITS-1:0] INV_SQRT2  = 31'sd759250125;
  localparam logic signed [COEF_BITS-1:0] INV_SQRT3  = 31'sd619925131;
  localparam logic signed [COEF_BITS-1:0] ROUND_HALF = 31'sd536870912;
  localparam trig_t CORDIC_K = 32'sd652032874;

  localparam trig_t ATAN_PHASE [ATAN_COUNT] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

endpackage

### hdl/cpdq_clarke.sv
module cpdq_clarke #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req,
  input  logic signed [SAMPLE_BITS-1:0] v_ab,
  input  logic signed [SAMPLE_BITS-1:0] v_bc,
  input  logic signed [SAMPLE_BITS-1:0] v_ca,
  input  logic        [ANGLE_BITS-1:0]  angle,
  output logic                          valid,
  output logic signed [SAMPLE_BITS+1:0] al,
  output logic signed [SAMPLE_BITS+1:0] be,
  output cpdq_pkg::trig_t               z,
  output cpdq_pkg::quad_t               quad
);
  import cpdq_pkg::*;

  localparam int AW = SAMPLE_BITS + 2;
  localparam int PW = AW + COEF_BITS;

  logic                 valid_s1;
  logic signed [AW-1:0] sum_a, sum_a_next;
  logic signed [AW-2:0] diff_b, diff_b_next;
  trig_t                z_s1, z_next;
  quad_t                quad_s1;
  logic signed [AW-1:0] ab_w, bc_w, ca_w;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [PW-1:0] rnd_a, rnd_b;

  assign ab_w = {{2{v_ab[SAMPLE_BITS-1]}}, v_ab};
  assign bc_w = {{2{v_bc[SAMPLE_BITS-1]}}, v_bc};
  assign ca_w = {{2{v_ca[SAMPLE_BITS-1]}}, v_ca};

  assign sum_a_next  = (ab_w <<< 1) - bc_w - ca_w;
  assign diff_b_next = (AW-1)'(bc_w - ca_w);
  assign z_next      = {2'b00, angle[ANGLE_BITS-3:0], {(PHASE_BITS - ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid    <= 1'b0;
    end else begin
      valid_s1 <= req;
      valid    <= valid_s1;
    end
  end

  // stage 1: line sums, stage 2: scaling products
  always_ff @(posedge clk) begin
    sum_a   <= sum_a_next;
    diff_b  <= diff_b_next;
    z_s1    <= z_next;
    quad_s1 <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    prod_a  <= PW'(sum_a) * PW'(INV_SQRT6);
    prod_b  <= PW'(diff_b) * PW'(INV_SQRT2);
    z       <= z_s1;
    quad    <= quad_s1;
  end

  assign rnd_a = (prod_a + PW'(ROUND_HALF)) >>> FRAC_BITS;
  assign rnd_b = (prod_b + PW'(ROUND_HALF)) >>> FRAC_BITS;
  assign al    = rnd_a[AW-1:0];
  assign be    = rnd_b[AW-1:0];

endmodule

### hdl/cpdq_cell.sv
module cpdq_cell #(
  parameter int AW    = 18,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  cpdq_pkg::trig_t      x_in,
  input  cpdq_pkg::trig_t      y_in,
  input  cpdq_pkg::trig_t      z_in,
  input  cpdq_pkg::quad_t      quad_in,
  input  logic signed [AW-1:0] al_in,
  input  logic signed [AW-1:0] be_in,
  output logic                 valid,
  output cpdq_pkg::trig_t      x,
  output cpdq_pkg::trig_t      y,
  output cpdq_pkg::trig_t      z,
  output cpdq_pkg::quad_t      quad,
  output logic signed [AW-1:0] al,
  output logic signed [AW-1:0] be
);
  import cpdq_pkg::*;

  trig_t dx, dy;
  trig_t x_next, y_next, z_next;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  // rotate toward zero residual angle
  always_comb begin
    if (!z_in[PHASE_BITS-1]) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN_PHASE[STAGE];
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN_PHASE[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x    <= x_next;
    y    <= y_next;
    z    <= z_next;
    quad <= quad_in;
    al   <= al_in;
    be   <= be_in;
  end

endmodule

### hdl/cpdq_park.sv
module cpdq_park #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  cpdq_pkg::trig_t               x_in,
  input  cpdq_pkg::trig_t               y_in,
  input  cpdq_pkg::quad_t               quad_in,
  input  logic signed [SAMPLE_BITS+1:0] al_in,
  input  logic signed [SAMPLE_BITS+1:0] be_in,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] v_alpha,
  output logic signed [SAMPLE_BITS-1:0] v_beta,
  output logic signed [SAMPLE_BITS-1:0] v_d,
  output logic signed [SAMPLE_BITS-1:0] v_q
);
  import cpdq_pkg::*;

  localparam int AW  = SAMPLE_BITS + 2;
  localparam int MW  = AW + PHASE_BITS;
  localparam int DW  = SAMPLE_BITS + 4;
  localparam int SW  = DW + 1;
  localparam int QW  = DW + COEF_BITS;
  localparam logic signed [SW-1:0] MAXV = {{(SW - SAMPLE_BITS + 1){1'b0}},
                                           {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > MAXV) begin
      r = MAXV[SAMPLE_BITS-1:0];
    end else if (v < MINV) begin
      r = MINV[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  trig_t                 c, s;
  logic                  valid_m, valid_r, valid_p;
  logic signed [MW-1:0]  pc_a, ps_b, pc_b, ps_a;
  logic signed [AW-1:0]  al_m, be_m, al_r, be_r, al_p, be_p;
  logic signed [MW:0]    sum_d, sum_q;
  logic signed [DW-1:0]  dd, qq;
  logic signed [QW-1:0]  prod_d, prod_q;
  logic signed [QW-1:0]  rnd_d, rnd_q;

  // quadrant fold-out
  always_comb begin
    case (quad_in)
      2'd0: begin
        c = x_in;
        s = y_in;
      end
      2'd1: begin
        c = -y_in;
        s = x_in;
      end
      2'd2: begin
        c = -x_in;
        s = -y_in;
      end
      default: begin
        c = y_in;
        s = -x_in;
      end
    endcase
  end

  assign sum_d = ((MW+1)'(pc_a) + (MW+1)'(ps_b) + (MW+1)'(ROUND_HALF)) >>> FRAC_BITS;
  assign sum_q = ((MW+1)'(pc_b) - (MW+1)'(ps_a) + (MW+1)'(ROUND_HALF)) >>> FRAC_BITS;
  assign rnd_d = (prod_d + QW'(ROUND_HALF)) >>> FRAC_BITS;
  assign rnd_q = (prod_q + QW'(ROUND_HALF)) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= 1'b0;
      valid_r <= 1'b0;
      valid_p <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_m <= valid_in;
      valid_r <= valid_m;
      valid_p <= valid_r;
      done    <= valid_p;
    end
  end

  always_ff @(posedge clk) begin
    pc_a    <= MW'(c) * MW'(al_in);
    ps_b    <= MW'(s) * MW'(be_in);
    pc_b    <= MW'(c) * MW'(be_in);
    ps_a    <= MW'(s) * MW'(al_in);
    al_m    <= al_in;
    be_m    <= be_in;
    dd      <= sum_d[DW-1:0];
    qq      <= sum_q[DW-1:0];
    al_r    <= al_m;
    be_r    <= be_m;
    prod_d  <= QW'(dd) * QW'(INV_SQRT3);
    prod_q  <= QW'(qq) * QW'(INV_SQRT3);
    al_p    <= al_r;
    be_p    <= be_r;
    v_alpha <= sat(SW'(al_p));
    v_beta  <= sat(SW'(be_p));
    v_d     <= sat(rnd_d[SW-1:0]);
    v_q     <= sat(rnd_q[SW-1:0]);
  end

endmodule

### hdl/clarke_park_dq_transform.sv
// channel   signals                          direction  timing
// request   start, busy, v_ab v_bc v_ca angle  in       taken when start and not busy
// result    done, v_alpha v_beta v_d v_q       out      one cycle, no back-pressure
//
// fully pipelined: one request per clock, busy never rises
// the pipe is two clarke stages, then a chain of TRIG_STAGES cordic
// cells, then four park stages
// synchronous reset clears the valid flags along the pipe only
// the receiver cannot stall, so nothing waits anywhere in the pipe
module clarke_park_dq_transform #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] v_ab,
  input  logic signed [SAMPLE_BITS-1:0] v_bc,
  input  logic signed [SAMPLE_BITS-1:0] v_ca,
  input  logic        [ANGLE_BITS-1:0]  angle,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] v_alpha,
  output logic signed [SAMPLE_BITS-1:0] v_beta,
  output logic signed [SAMPLE_BITS-1:0] v_d,
  output logic signed [SAMPLE_BITS-1:0] v_q
);
  import cpdq_pkg::*;

  localparam int AW = SAMPLE_BITS + 2;

  logic                 valid_c [TRIG_STAGES+1];
  trig_t                x_c     [TRIG_STAGES+1];
  trig_t                y_c     [TRIG_STAGES+1];
  trig_t                z_c     [TRIG_STAGES+1];
  quad_t                quad_c  [TRIG_STAGES+1];
  logic signed [AW-1:0] al_c    [TRIG_STAGES+1];
  logic signed [AW-1:0] be_c    [TRIG_STAGES+1];

  assign busy   = 1'b0;
  assign x_c[0] = CORDIC_K;
  assign y_c[0] = '0;

  cpdq_clarke #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_clarke (
    .clk   (clk),
    .rst   (rst),
    .req   (start & ~busy),
    .v_ab  (v_ab),
    .v_bc  (v_bc),
    .v_ca  (v_ca),
    .angle (angle),
    .valid (valid_c[0]),
    .al    (al_c[0]),
    .be    (be_c[0]),
    .z     (z_c[0]),
    .quad  (quad_c[0])
  );

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
    cpdq_cell #(
      .AW    (AW),
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (valid_c[i]),
      .x_in     (x_c[i]),
      .y_in     (y_c[i]),
      .z_in     (z_c[i]),
      .quad_in  (quad_c[i]),
      .al_in    (al_c[i]),
      .be_in    (be_c[i]),
      .valid    (valid_c[i+1]),
      .x        (x_c[i+1]),
      .y        (y_c[i+1]),
      .z        (z_c[i+1]),
      .quad     (quad_c[i+1]),
      .al       (al_c[i+1]),
      .be       (be_c[i+1])
    );
  end

  cpdq_park #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_park (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid_c[TRIG_STAGES]),
    .x_in     (x_c[TRIG_STAGES]),
    .y_in     (y_c[TRIG_STAGES]),
    .quad_in  (quad_c[TRIG_STAGES]),
    .al_in    (al_c[TRIG_STAGES]),
    .be_in    (be_c[TRIG_STAGES]),
    .done     (done),
    .v_alpha  (v_alpha),
    .v_beta   (v_beta),
    .v_d      (v_d),
    .v_q      (v_q)
  );

endmodule
